// ===== rtl/core/first_fit_segment_allocator_unit_macros.svh =====
// assertion macros for the segment allocator checker
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH

// implication checked at every edge outside reset
`define FFSA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FFSA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// types and constants shared by the segment allocator modules
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 64;
    localparam int unsigned OFFSET_BITS_DEF  = 32;
    localparam int unsigned DATA_BITS        = 32;
    localparam int unsigned STATUS_BITS      = 3;
    localparam logic [DATA_BITS-1:0] CAPACITY_RESET = 32'd65536;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_FIT   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_FREE = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        t_IDLE,
        t_SCAN,
        t_EVAL,
        t_SHIFT,
        t_DONE
    } t_state;

    // shift operation applied to the whole cell row
    typedef enum logic [1:0] {
        t_SH_NONE,
        t_SH_OPEN,
        t_SH_CLOSE
    } t_shift_op;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic      load;
        logic      rotate;
        t_shift_op op;
        logic      wr;
        logic      wr_free;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/ffsa_cell.sv =====
// ----------------------------------------------------------------------------
// ffsa_cell
// one table entry: start, length and free flag with neighbor shift links
// ----------------------------------------------------------------------------
module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter int unsigned OW = OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic          i_first,
    input  logic          i_sel,
    input  logic [OW-1:0] i_load_len,
    input  logic [OW-1:0] i_wr_start,
    input  logic [OW-1:0] i_wr_len,
    input  logic [OW-1:0] i_prev_start,
    input  logic [OW-1:0] i_prev_len,
    input  logic          i_prev_free,
    input  logic          i_open_here,
    input  logic          i_close_here,
    input  logic [OW-1:0] i_next_start,
    input  logic [OW-1:0] i_next_len,
    input  logic          i_next_free,
    output logic [OW-1:0] o_start,
    output logic [OW-1:0] o_len,
    output logic          o_free
);

    logic [OW-1:0] r_start, n_start;
    logic [OW-1:0] r_len, n_len;
    logic          r_free, n_free;

    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_free  = r_free;
        if (i_ctrl.load) begin
            n_start = '0;
            n_len   = i_first ? i_load_len : '0;
            n_free  = i_first;
        end else if (i_ctrl.rotate) begin
            n_start = i_next_start;
            n_len   = i_next_len;
            n_free  = i_next_free;
        end else begin
            if (i_ctrl.op == t_SH_OPEN && i_open_here) begin
                n_start = i_prev_start;
                n_len   = i_prev_len;
                n_free  = i_prev_free;
            end else if (i_ctrl.op == t_SH_CLOSE && i_close_here) begin
                n_start = i_next_start;
                n_len   = i_next_len;
                n_free  = i_next_free;
            end
            if (i_ctrl.wr && i_sel) begin
                n_start = i_wr_start;
                n_len   = i_wr_len;
                n_free  = i_ctrl.wr_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
        r_free  <= n_free;
    end

    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_free  = r_free;

endmodule

// ===== rtl/core/ffsa_row.sv =====
// ----------------------------------------------------------------------------
// ffsa_row
// chain of table cells; rotates through the head for scanning and shifts
// entries to open or close one slot
// ----------------------------------------------------------------------------
module ffsa_row
    import ffsa_pkg::*;
#(
    parameter int unsigned NSEG = MAX_SEGMENTS_DEF,
    parameter int unsigned OW   = OFFSET_BITS_DEF,
    localparam int unsigned IW  = $clog2(NSEG)
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [IW-1:0] i_pos,
    input  logic [OW-1:0] i_load_len,
    input  logic [OW-1:0] i_wr_start,
    input  logic [OW-1:0] i_wr_len,
    output logic [OW-1:0] o_head_start,
    output logic [OW-1:0] o_head_len,
    output logic          o_head_free,
    output logic [OW-1:0] o_sel_start
);

    logic [OW-1:0] w_start [NSEG];
    logic [OW-1:0] w_len   [NSEG];
    logic          w_free  [NSEG];

    for (genvar g = 0; g < NSEG; g++) begin : g_cell
        localparam int unsigned P = (g == 0) ? NSEG - 1 : g - 1;
        localparam int unsigned N = (g == NSEG - 1) ? 0 : g + 1;
        ffsa_cell #(.OW(OW)) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_first      (g == 0),
            .i_sel        (i_pos == IW'(g)),
            .i_load_len   (i_load_len),
            .i_wr_start   (i_wr_start),
            .i_wr_len     (i_wr_len),
            .i_prev_start (w_start[P]),
            .i_prev_len   (w_len[P]),
            .i_prev_free  (w_free[P]),
            .i_open_here  ((g != 0) && (IW'(g) > i_pos)),
            .i_close_here ((g != NSEG - 1) && (IW'(g) >= i_pos)),
            .i_next_start (w_start[N]),
            .i_next_len   (w_len[N]),
            .i_next_free  (w_free[N]),
            .o_start      (w_start[g]),
            .o_len        (w_len[g]),
            .o_free       (w_free[g])
        );
    end

    assign o_head_start = w_start[0];
    assign o_head_len   = w_len[0];
    assign o_head_free  = w_free[0];
    assign o_sel_start  = w_start[i_pos];

endmodule

// ===== rtl/core/first_fit_segment_allocator_unit.sv =====
// Segment allocator for one page. The table lives in a row of cells that
// rotates one entry per cycle through the head cell: a request scans the
// whole row, so the row returns to its original order; then an allocate
// opens and writes slots for any padding and tail and writes the segment,
// and a free closes slots toward free neighbors and writes the merged entry;
// a refused request skips them. A new request is accepted only after the
// result has been taken. A capacity write reloads the page. A result waits
// in an output register.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit allocate and coalescing free over a table of segments
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [DATA_BITS-1:0]   i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [DATA_BITS-1:0]   i_request_size,
    input  logic [4:0]             i_align_log2,
    input  logic [DATA_BITS-1:0]   i_free_offset,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [DATA_BITS-1:0]   o_alloc_offset,
    output logic [DATA_BITS-1:0]   o_used_bytes
);

    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned OW = OFFSET_BITS;
    localparam int unsigned WW = OW + 1;
    localparam logic [63:0] OFF_MAX = (64'd1 << OW) - 64'd1;

    t_state r_state, n_state;
    t_cell_ctrl w_ctrl;

    logic [CW-1:0] r_count, n_count;
    logic [DATA_BITS-1:0] r_used, n_used;
    logic          r_cmd;
    logic          r_big;
    logic [OW-1:0] r_size, r_foff, r_align_m1;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_scan, n_scan;
    logic          r_found, n_found;
    logic [IW-1:0] r_hit, n_hit;
    logic [OW-1:0] r_hs, n_hs, r_hl, n_hl;
    logic          r_pfree, n_pfree;
    logic [OW-1:0] r_pl, n_pl;
    logic          r_nfree, n_nfree;
    logic [OW-1:0] r_nl, n_nl;
    logic          r_lastfree, n_lastfree;
    logic [OW-1:0] r_lastlen, n_lastlen;
    logic [2:0]    r_step, n_step;
    logic [IW-1:0] r_pos, n_pos;
    logic [OW-1:0] r_at, n_at;
    logic          r_pad, n_pad, r_tail, n_tail;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [DATA_BITS-1:0]   r_aoff, n_aoff;

    logic [OW-1:0] w_load_len, w_wr_start, w_wr_len;
    logic [OW-1:0] w_hs, w_hl, w_ss;
    logic          w_hf;
    logic [63:0]   w_cap_src, w_cap;
    logic [WW-1:0] w_at_ext, w_pad_ext;
    logic          w_live, w_fit;

    // capacity saturated to the offset range
    assign w_cap_src  = (i_rst_n && r_state == t_IDLE && i_cfg_valid) ? 64'(i_cfg_data)
                                                                      : 64'(CAPACITY_RESET);
    assign w_cap      = (w_cap_src > OFF_MAX) ? OFF_MAX : w_cap_src;
    assign w_load_len = w_cap[OW-1:0];

    ffsa_row #(.NSEG(MAX_SEGMENTS), .OW(OW)) u_row (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_pos        (r_pos),
        .i_load_len   (w_load_len),
        .i_wr_start   (w_wr_start),
        .i_wr_len     (w_wr_len),
        .o_head_start (w_hs),
        .o_head_len   (w_hl),
        .o_head_free  (w_hf),
        .o_sel_start  (w_ss)
    );

    // fit test on the head entry
    assign w_live    = r_scan < r_count;
    assign w_at_ext  = ({1'b0, w_hs} + {1'b0, r_align_m1}) & ~{1'b0, r_align_m1};
    assign w_pad_ext = w_at_ext - {1'b0, w_hs};
    assign w_fit     = w_hf && w_pad_ext <= {1'b0, w_hl}
                       && ({1'b0, w_hl} - w_pad_ext) >= {1'b0, r_size};

    assign o_ready     = r_state == t_IDLE && !i_cfg_valid;
    assign o_cfg_ready = r_state == t_IDLE;
    assign o_valid     = r_state == t_DONE;
    assign o_status    = r_status;
    assign o_alloc_offset = r_aoff;
    assign o_used_bytes   = r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_count <= CW'(1);
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_IDLE && i_valid && o_ready) begin
            r_cmd      <= i_command;
            r_size     <= OW'(i_request_size);
            r_foff     <= OW'(i_free_offset);
            r_align_m1 <= OW'((WW'(1) << i_align_log2) - WW'(1));
            // operand beyond the offset range
            r_big      <= (i_command == CMD_FREE ? 64'(i_free_offset)
                                                 : 64'(i_request_size)) > OFF_MAX;
        end
        r_idx <= n_idx; r_scan <= n_scan; r_found <= n_found; r_hit <= n_hit;
        r_hs <= n_hs; r_hl <= n_hl; r_pfree <= n_pfree; r_pl <= n_pl;
        r_nfree <= n_nfree; r_nl <= n_nl; r_lastfree <= n_lastfree;
        r_lastlen <= n_lastlen; r_step <= n_step; r_pos <= n_pos; r_at <= n_at;
        r_pad <= n_pad; r_tail <= n_tail;
        r_status <= n_status; r_aoff <= n_aoff;
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_used = r_used;
        n_idx = r_idx; n_scan = r_scan; n_found = r_found; n_hit = r_hit;
        n_hs = r_hs; n_hl = r_hl; n_pfree = r_pfree; n_pl = r_pl;
        n_nfree = r_nfree; n_nl = r_nl; n_lastfree = r_lastfree;
        n_lastlen = r_lastlen; n_step = r_step; n_pos = r_pos; n_at = r_at;
        n_pad = r_pad; n_tail = r_tail;
        n_status = r_status; n_aoff = r_aoff;
        w_ctrl = '{load: 1'b0, rotate: 1'b0, op: t_SH_NONE, wr: 1'b0, wr_free: 1'b0};
        w_wr_start = '0;
        w_wr_len   = '0;
        if (!i_rst_n) begin
            w_ctrl.load = 1'b1;
        end
        unique case (r_state)
            t_IDLE: begin
                if (i_cfg_valid) begin
                    w_ctrl.load = 1'b1;
                    n_count = CW'(1);
                    n_used  = '0;
                end else if (i_valid) begin
                    n_state = t_SCAN;
                    n_idx = '0; n_scan = '0; n_found = 1'b0;
                    n_lastfree = 1'b0; n_lastlen = '0;
                end
            end
            t_SCAN: begin
                w_ctrl.rotate = 1'b1;
                n_idx  = r_idx + IW'(1);
                n_scan = r_scan + CW'(1);
                if (w_live) begin
                    if (r_found && r_idx == r_hit + IW'(1)) begin
                        n_nfree = w_hf; n_nl = w_hl;
                    end
                    if (!r_found) begin
                        if (r_cmd == CMD_ALLOC ? w_fit
                                : (!w_hf && w_hs == r_foff)) begin
                            n_found = 1'b1; n_hit = r_idx;
                            n_hs = w_hs; n_hl = w_hl;
                            n_at = w_at_ext[OW-1:0];
                            n_pad = w_pad_ext != '0;
                            n_tail = ({1'b0, w_hl} - w_pad_ext) > {1'b0, r_size};
                            n_pfree = r_lastfree; n_pl = r_lastlen;
                            n_nfree = 1'b0; n_nl = '0;
                        end
                    end
                    n_lastfree = w_hf; n_lastlen = w_hl;
                end
                if (r_scan == CW'(MAX_SEGMENTS - 1)) begin
                    n_state = t_EVAL;
                end
            end
            t_EVAL: begin
                n_state = t_SHIFT;
                n_step = '0;
                n_aoff = '0;
                n_status = ST_OK;
                if (r_cmd == CMD_ALLOC) begin
                    if (r_size == '0 && !r_big) begin
                        n_status = ST_ZERO; n_state = t_DONE;
                    end else if (!r_found || r_big) begin
                        n_status = ST_NO_FIT; n_state = t_DONE;
                    end else if ({1'b0, r_count} + CW'(r_pad) + CW'(r_tail)
                                 > (CW+1)'(MAX_SEGMENTS)) begin
                        n_status = ST_FULL; n_state = t_DONE;
                    end else begin
                        n_aoff = DATA_BITS'(r_at);
                        n_used = r_used + DATA_BITS'(r_size);
                        n_pos = r_hit;
                    end
                end else if (!r_found || r_big) begin
                    n_status = ST_BAD_FREE; n_state = t_DONE;
                end else begin
                    n_used = r_used - DATA_BITS'(r_hl);
                    n_pos = r_hit;
                end
            end
            t_SHIFT: begin
                n_step = r_step + 3'd1;
                if (r_cmd == CMD_ALLOC) begin
                    unique case (r_step)
                        3'd0: begin
                            if (r_pad) begin
                                w_ctrl.op = t_SH_OPEN;
                                n_count = r_count + CW'(1);
                            end
                        end
                        3'd1: begin
                            if (r_pad) begin
                                w_ctrl.wr = 1'b1; w_ctrl.wr_free = 1'b1;
                                w_wr_start = r_hs; w_wr_len = r_at - r_hs;
                                n_pos = r_pos + IW'(1);
                            end
                        end
                        3'd2: begin
                            if (r_tail) begin
                                w_ctrl.op = t_SH_OPEN;
                                n_count = r_count + CW'(1);
                            end
                        end
                        3'd3: begin
                            w_ctrl.wr = 1'b1; w_ctrl.wr_free = 1'b0;
                            w_wr_start = r_at; w_wr_len = r_size;
                            n_pos = r_pos + IW'(1);
                        end
                        3'd4: begin
                            if (r_tail) begin
                                w_ctrl.wr = 1'b1; w_ctrl.wr_free = 1'b1;
                                w_wr_start = r_at + r_size;
                                w_wr_len = r_hl - (r_at - r_hs) - r_size;
                            end
                            n_state = t_DONE;
                        end
                        default: n_state = t_DONE;
                    endcase
                end else begin
                    unique case (r_step)
                        3'd0: begin
                            if (r_hit != '0 && r_pfree) begin
                                w_ctrl.op = t_SH_CLOSE;
                                n_count = r_count - CW'(1);
                                n_pos = r_pos - IW'(1);
                            end
                        end
                        3'd1: begin
                            if (r_nfree) begin
                                n_pos = r_pos + IW'(1);
                            end
                        end
                        3'd2: begin
                            if (r_nfree) begin
                                w_ctrl.op = t_SH_CLOSE;
                                n_count = r_count - CW'(1);
                                n_pos = r_pos - IW'(1);
                            end
                        end
                        3'd3: begin
                            w_ctrl.wr = 1'b1; w_ctrl.wr_free = 1'b1;
                            w_wr_start = (r_hit != '0 && r_pfree) ? w_ss : r_hs;
                            w_wr_len = ((r_hit != '0 && r_pfree) ? r_pl : '0) + r_hl
                                       + (r_nfree ? r_nl : '0);
                            n_state = t_DONE;
                        end
                        default: n_state = t_DONE;
                    endcase
                end
            end
            t_DONE: begin
                if (i_ready) begin
                    n_state = t_IDLE;
                end
            end
            default: n_state = t_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ffsa_checker.sv =====
// ----------------------------------------------------------------------------
// ffsa_checker
// port-level checks of the segment allocator
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_unit_macros.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [STATUS_BITS-1:0] o_status,
    input logic [DATA_BITS-1:0]   o_alloc_offset,
    input logic [DATA_BITS-1:0]   o_used_bytes
);

    `FFSA_ASSERT_NEXT(a_in_then_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
        "input taken while a transaction is in flight")
    `FFSA_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready && !o_cfg_ready,
        "new transaction accepted while a result is pending")
    `FFSA_ASSERT_IMP(a_offset_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_alloc_offset == '0, "offset not zero on a failed transaction")
    `FFSA_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready,
        o_used_bytes == '0, "capacity write did not clear used bytes")

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (.*);
